// File: rtl/swlu_pkg.sv
// shared types and constants for the soil worm lattice update block
// no dependencies

package swlu_pkg;

    localparam int unsigned SIDE_DEFAULT = 256;
    localparam int unsigned COORD_IN_W   = 8;
    localparam int unsigned COORD_SPAN   = 1 << COORD_IN_W;
    localparam int unsigned DRAW_W       = 16;
    localparam int unsigned RATE_W       = 17;
    localparam int unsigned CFG_IDX_W    = 2;

    localparam logic [RATE_W-1:0] FILL_RATE_RST      = 17'd6554;
    localparam logic [RATE_W-1:0] DEATH_RATE_RST     = 17'd7930;
    localparam logic [RATE_W-1:0] REPRODUCE_RATE_RST = 17'd65536;
    localparam logic [RATE_W-1:0] NUTRIENT_RATE_RST  = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_FILL_RATE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH_RATE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPRODUCE_RATE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NUTRIENT_RATE  = 2'd3;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_READ   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CELL_EMPTY    = 2'd0,
        CELL_NUTRIENT = 2'd1,
        CELL_SOIL     = 2'd2,
        CELL_WORM     = 2'd3
    } cell_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_FILLED     = 3'd1,
        EV_DIED       = 3'd2,
        EV_MOVED      = 3'd3,
        EV_REPRODUCED = 3'd4,
        EV_NUTRIENT   = 3'd5,
        EV_BLOCKED    = 3'd6
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_SITE,
        ST_RD_WAIT,
        ST_RD_NBR,
        ST_EVAL,
        ST_WR_NBR,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic latch;
        logic wr_load;
        logic rd_site;
        logic cap_read;
        logic rd_nbr;
        logic eval;
        logic wr_nbr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic [1:0] op;
        logic       nbr_wr;
    } status_t;

endpackage

// File: rtl/swlu_ctrl.sv
// sequencer for load, read and update items over the single lattice port
// depends on swlu_pkg

module swlu_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  swlu_pkg::status_t status,
    output swlu_pkg::cmd_t   cmd
);
    import swlu_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch = 1'b1;
                    if (status.in_op == OP_LOAD)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_RD_SITE;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.wr_load = 1'b1;
                state_next  = ST_FIN;
            end
            ST_RD_SITE:
            begin
                cmd.rd_site = 1'b1;
                if (status.op == OP_UPDATE)
                begin
                    state_next = ST_RD_NBR;
                end
                else
                begin
                    state_next = ST_RD_WAIT;
                end
            end
            ST_RD_WAIT:
            begin
                cmd.cap_read = 1'b1;
                state_next   = ST_FIN;
            end
            ST_RD_NBR:
            begin
                cmd.rd_nbr = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.nbr_wr)
                begin
                    state_next = ST_WR_NBR;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end
            ST_WR_NBR:
            begin
                cmd.wr_nbr = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/swlu_dp.sv
// lattice memory, rate registers, coordinate wrap and update decision
// depends on swlu_pkg

module swlu_dp
#(
    parameter int unsigned SIDE = swlu_pkg::SIDE_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [1:0]                       operation,
    input  logic [swlu_pkg::COORD_IN_W-1:0]  site_x,
    input  logic [swlu_pkg::COORD_IN_W-1:0]  site_y,
    input  logic [1:0]                       direction,
    input  logic [swlu_pkg::DRAW_W-1:0]      first_draw,
    input  logic [swlu_pkg::DRAW_W-1:0]      second_draw,
    input  logic [1:0]                       load_value,
    input  logic                             cfg_we,
    input  logic [swlu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swlu_pkg::RATE_W-1:0]      cfg_data,
    input  swlu_pkg::cmd_t                   cmd,
    output swlu_pkg::status_t                status,
    output logic [1:0]                       cell_value,
    output logic [2:0]                       event_res
);
    import swlu_pkg::*;

    localparam int unsigned CW    = $clog2(SIDE);
    localparam int unsigned DEPTH = SIDE * SIDE;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [CW-1:0] LAST   = CW'(SIDE - 1);
    localparam logic [AW-1:0] SIDE_A = AW'(SIDE);

    logic [RATE_W-1:0] fill_rate_reg;
    logic [RATE_W-1:0] death_rate_reg;
    logic [RATE_W-1:0] reproduce_rate_reg;
    logic [RATE_W-1:0] nutrient_rate_reg;

    logic [CW-1:0] mod_tab [COORD_SPAN];

    logic [1:0]        op_reg;
    logic [CW-1:0]     x_reg;
    logic [CW-1:0]     y_reg;
    logic [CW-1:0]     nx_reg;
    logic [CW-1:0]     ny_reg;
    logic [DRAW_W-1:0] d1_reg;
    logic [DRAW_W-1:0] d2_reg;
    cell_t             load_reg;
    cell_t             here_reg;
    cell_t             res_cell_reg;
    event_t            res_event_reg;
    cell_t             out_cell_reg;
    event_t            out_event_reg;

    logic [1:0] mem [DEPTH];
    cell_t      rdata_reg;

    logic [CW-1:0] x_mod;
    logic [CW-1:0] y_mod;
    logic [CW-1:0] x_nbr;
    logic [CW-1:0] y_nbr;
    logic [AW-1:0] site_addr;
    logic [AW-1:0] nbr_addr;
    logic [AW-1:0] mem_addr;
    logic          mem_we;
    logic [1:0]    mem_wdata;

    logic   fill_pass;
    logic   death_pass;
    logic   repro_pass;
    logic   nutr_pass;
    cell_t  site_code;
    logic   site_wr;
    logic   nbr_wr;
    event_t new_event;

    // coordinate wrap table, constant
    for (genvar i = 0; i < COORD_SPAN; i++)
    begin : g_mod
        localparam logic [CW-1:0] MV = CW'(i % SIDE);
        assign mod_tab[i] = MV;
    end

    assign x_mod = mod_tab[site_x];
    assign y_mod = mod_tab[site_y];

    always_comb
    begin
        x_nbr = x_mod;
        y_nbr = y_mod;
        if (!direction[1])
        begin
            if (direction[0])
            begin
                x_nbr = (x_mod == LAST) ? '0 : x_mod + 1'b1;
            end
            else
            begin
                x_nbr = (x_mod == '0) ? LAST : x_mod - 1'b1;
            end
        end
        else
        begin
            if (direction[0])
            begin
                y_nbr = (y_mod == LAST) ? '0 : y_mod + 1'b1;
            end
            else
            begin
                y_nbr = (y_mod == '0) ? LAST : y_mod - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_rate_reg      <= FILL_RATE_RST;
            death_rate_reg     <= DEATH_RATE_RST;
            reproduce_rate_reg <= REPRODUCE_RATE_RST;
            nutrient_rate_reg  <= NUTRIENT_RATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FILL_RATE:      fill_rate_reg      <= cfg_data;
                CFG_DEATH_RATE:     death_rate_reg     <= cfg_data;
                CFG_REPRODUCE_RATE: reproduce_rate_reg <= cfg_data;
                CFG_NUTRIENT_RATE:  nutrient_rate_reg  <= cfg_data;
                default:            fill_rate_reg      <= fill_rate_reg;
            endcase
        end
    end

    // item capture; op is shown to the sequencer straight from the port while idle
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= operation;
            x_reg    <= x_mod;
            y_reg    <= y_mod;
            nx_reg   <= x_nbr;
            ny_reg   <= y_nbr;
            d1_reg   <= first_draw;
            d2_reg   <= second_draw;
            load_reg <= cell_t'(load_value);
        end
    end

    assign site_addr = AW'(x_reg) * SIDE_A + AW'(y_reg);
    assign nbr_addr  = AW'(nx_reg) * SIDE_A + AW'(ny_reg);

    assign fill_pass  = {1'b0, d1_reg} < fill_rate_reg;
    assign death_pass = {1'b0, d1_reg} < death_rate_reg;
    assign repro_pass = {1'b0, d2_reg} < reproduce_rate_reg;
    assign nutr_pass  = {1'b0, d2_reg} < nutrient_rate_reg;

    // rdata_reg holds the neighbor code during eval
    always_comb
    begin
        site_code = here_reg;
        site_wr   = 1'b0;
        nbr_wr    = 1'b0;
        new_event = EV_NONE;
        case (here_reg) inside
            CELL_EMPTY, CELL_NUTRIENT:
            begin
                if (rdata_reg == CELL_SOIL && fill_pass)
                begin
                    site_code = CELL_SOIL;
                    site_wr   = 1'b1;
                    new_event = EV_FILLED;
                end
            end
            CELL_WORM:
            begin
                site_wr = 1'b1;
                if (death_pass)
                begin
                    site_code = CELL_EMPTY;
                    new_event = EV_DIED;
                end
                else
                begin
                    nbr_wr    = 1'b1;
                    site_code = CELL_EMPTY;
                    new_event = EV_MOVED;
                    case (rdata_reg)
                        CELL_NUTRIENT:
                        begin
                            if (repro_pass)
                            begin
                                site_code = CELL_WORM;
                                new_event = EV_REPRODUCED;
                            end
                        end
                        CELL_SOIL:
                        begin
                            if (nutr_pass)
                            begin
                                site_code = CELL_NUTRIENT;
                                new_event = EV_NUTRIENT;
                            end
                        end
                        CELL_WORM:
                        begin
                            site_code = CELL_WORM;
                            new_event = EV_BLOCKED;
                        end
                        default:
                        begin
                            site_code = CELL_EMPTY;
                        end
                    endcase
                end
            end
            default:
            begin
                site_code = here_reg;
            end
        endcase
    end

    always_comb
    begin
        mem_addr  = site_addr;
        mem_we    = 1'b0;
        mem_wdata = load_reg;
        if (cmd.rd_nbr || cmd.wr_nbr)
        begin
            mem_addr = nbr_addr;
        end
        if (cmd.wr_load)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.eval && site_wr)
        begin
            mem_we    = 1'b1;
            mem_wdata = site_code;
        end
        else if (cmd.wr_nbr)
        begin
            mem_we    = 1'b1;
            mem_wdata = CELL_WORM;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.rd_site || cmd.rd_nbr)
        begin
            rdata_reg <= cell_t'(mem[mem_addr]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_nbr)
        begin
            here_reg <= rdata_reg;
        end
        if (cmd.wr_load)
        begin
            res_cell_reg  <= load_reg;
            res_event_reg <= EV_NONE;
        end
        else if (cmd.cap_read)
        begin
            res_cell_reg  <= rdata_reg;
            res_event_reg <= EV_NONE;
        end
        else if (cmd.eval)
        begin
            res_cell_reg  <= site_code;
            res_event_reg <= new_event;
        end
        if (cmd.out_load)
        begin
            out_cell_reg  <= res_cell_reg;
            out_event_reg <= res_event_reg;
        end
    end

    assign status.in_op  = operation;
    assign status.op     = op_reg;
    assign status.nbr_wr = nbr_wr;
    assign cell_value    = out_cell_reg;
    assign event_res     = out_event_reg;

endmodule

// File: rtl/soil_worm_lattice_update_top.sv
// top level of the soil worm lattice update block
// depends on swlu_pkg, swlu_ctrl and swlu_dp
//
//   channel  handshake             payload
//   in       in_valid / in_ready   operation site_x site_y direction first_draw
//                                  second_draw load_value
//   out      out_valid / out_ready cell_value event_res
//   cfg      cfg_we                cfg_index cfg_data
//
// one item at a time: a load steps through load and finish, a read through
// site read, read wait and finish, an update through site read, neighbor read,
// eval, neighbor write (when a worm survives the death test) and finish,
// over the single lattice port, one access per cycle; reset idles the
// sequencer, loads default rates; lattice cells are undefined until loaded
// a result waiting in the output register holds the next item at its last step

module soil_worm_lattice_update_top
#(
    parameter int unsigned SIDE = swlu_pkg::SIDE_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [1:0]                       operation,
    input  logic [swlu_pkg::COORD_IN_W-1:0]  site_x,
    input  logic [swlu_pkg::COORD_IN_W-1:0]  site_y,
    input  logic [1:0]                       direction,
    input  logic [swlu_pkg::DRAW_W-1:0]      first_draw,
    input  logic [swlu_pkg::DRAW_W-1:0]      second_draw,
    input  logic [1:0]                       load_value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       cell_value,
    output logic [2:0]                       event_res,
    input  logic                             cfg_we,
    input  logic [swlu_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [swlu_pkg::RATE_W-1:0]      cfg_data
);
    import swlu_pkg::*;

    cmd_t    cmd;
    status_t status;

    swlu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    swlu_dp #(
        .SIDE (SIDE)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .site_x      (site_x),
        .site_y      (site_y),
        .direction   (direction),
        .first_draw  (first_draw),
        .second_draw (second_draw),
        .load_value  (load_value),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .cell_value  (cell_value),
        .event_res   (event_res)
    );

endmodule

// File: rtl/swlu_chk.sv
// port-level checks for the soil worm lattice update block, bound to the top
// depends on swlu_pkg and soil_worm_lattice_update_top

module swlu_chk
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] cell_value,
    input logic [2:0] event_res
);
    import swlu_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_value) && $stable(event_res))
        else $error("output beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second beat taken while an item is in work");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> event_res != 3'd7)
        else $error("event code out of range");

    a_event_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (event_res == EV_NONE) ||
            (event_res == EV_FILLED && cell_value == CELL_SOIL) ||
            (event_res == EV_DIED && cell_value == CELL_EMPTY) ||
            (event_res == EV_MOVED && cell_value == CELL_EMPTY) ||
            (event_res == EV_REPRODUCED && cell_value == CELL_WORM) ||
            (event_res == EV_NUTRIENT && cell_value == CELL_NUTRIENT) ||
            (event_res == EV_BLOCKED && cell_value == CELL_WORM))
        else $error("site code does not match event");

endmodule

bind soil_worm_lattice_update_top swlu_chk u_swlu_chk
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cell_value (cell_value),
    .event_res  (event_res)
);
